/* src/tdsm_pkg.sv */
// Shared types and constants for the table-driven state machine unit.
package tdsm_pkg;

    localparam int RC_W       = 5;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 4'd1;

    typedef enum logic [1:0] {
        OP_EVENT   = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_TAKEN   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_STORED  = 2'd2,
        ST_RESTART = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } seq_state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

/* src/tdsm_if.sv */
// Channel interfaces: request stream, response stream, configuration writes.
interface tdsm_req_if
    import tdsm_pkg::*;
#(
    parameter int STATE_BITS = 8,
    parameter int EVENT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [SLOT_W-1:0]     rule_slot;
    logic [STATE_BITS-1:0] rule_from;
    logic [EVENT_BITS-1:0] rule_event;
    logic [STATE_BITS-1:0] rule_to;
    logic                  rule_notify;
    logic [EVENT_BITS-1:0] event_req;

    modport source (output valid, opcode, rule_slot, rule_from, rule_event, rule_to,
                    rule_notify, event_req, input ready);
    modport sink   (input valid, opcode, rule_slot, rule_from, rule_event, rule_to,
                    rule_notify, event_req, output ready);
endinterface

interface tdsm_rsp_if
    import tdsm_pkg::*;
#(
    parameter int STATE_BITS = 8,
    parameter int EVENT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [STATE_BITS-1:0] prior_state;
    logic [STATE_BITS-1:0] next_state;
    logic                  notify;
    logic [EVENT_BITS-1:0] event_echo;

    modport source (output valid, status, prior_state, next_state, notify, event_echo,
                    input ready);
    modport sink   (input valid, status, prior_state, next_state, notify, event_echo,
                    output ready);
endinterface

interface tdsm_cfg_if
    import tdsm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/tdsm_rule_mem.sv */
// Rule store: one write port, one registered read port.
module tdsm_rule_mem
    import tdsm_pkg::*;
#(
    parameter int RULE_SLOTS = 16,
    parameter int IDX_W      = 4,
    parameter int RULE_W     = 25
) (
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [RULE_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [RULE_W-1:0] rdata
);

    logic [RULE_W-1:0] mem [RULE_SLOTS];
    logic [RULE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tdsm_seq.sv */
// Sequencer: decodes requests, scans rules one per cycle, holds the response register.
module tdsm_seq
    import tdsm_pkg::*;
#(
    parameter int RULE_SLOTS = 16,
    parameter int STATE_BITS = 8,
    parameter int EVENT_BITS = 8,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int RULE_W     = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tdsm_req_if.sink              req,
    tdsm_rsp_if.source            rsp,
    input  logic [RC_W-1:0]       rule_count,
    input  logic [STATE_BITS-1:0] start_state,
    output mem_ctl_t              mem_ctl,
    output logic [IDX_W-1:0]      mem_waddr,
    output logic [RULE_W-1:0]     mem_wdata,
    output logic [IDX_W-1:0]      mem_raddr,
    input  logic [RULE_W-1:0]     mem_rdata,
    output seq_state_t            seq_state,
    output logic [CNT_W-1:0]      scan_index,
    output logic [CNT_W-1:0]      scan_limit
);

    localparam int CW = (CNT_W > RC_W) ? CNT_W : RC_W;

    seq_state_t            state_reg;
    logic [STATE_BITS-1:0] cur_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      lim_reg;
    logic [EVENT_BITS-1:0] ev_reg;
    logic                  rsp_valid_reg;
    status_t               status_reg;
    logic [STATE_BITS-1:0] prior_reg;
    logic [STATE_BITS-1:0] next_reg;
    logic                  notify_reg;
    logic [EVENT_BITS-1:0] echo_reg;

    logic                  accept;
    logic [CNT_W-1:0]      lim;
    logic [CNT_W-1:0]      idx_plus1;
    logic                  last;
    logic                  match;
    logic [STATE_BITS-1:0] rd_from;
    logic [EVENT_BITS-1:0] rd_event;
    logic [STATE_BITS-1:0] rd_to;
    logic                  rd_notify;
    logic                  res_load;
    status_t               res_status;
    logic [STATE_BITS-1:0] res_next;
    logic                  res_notify;
    logic [EVENT_BITS-1:0] res_echo;
    logic                  slot_ok;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign lim = (CW'(rule_count) > CW'(RULE_SLOTS)) ? CNT_W'(RULE_SLOTS)
                                                     : CNT_W'(rule_count);
    assign idx_plus1 = idx_reg + CNT_W'(1);
    assign last      = (idx_plus1 == lim_reg);

    assign rd_notify = mem_rdata[0];
    assign rd_to     = mem_rdata[STATE_BITS:1];
    assign rd_event  = mem_rdata[STATE_BITS+EVENT_BITS:STATE_BITS+1];
    assign rd_from   = mem_rdata[RULE_W-1 -: STATE_BITS];
    assign match     = (rd_from == cur_reg) && (rd_event == ev_reg);

    assign slot_ok   = (32'(req.rule_slot) < 32'(RULE_SLOTS));
    assign mem_waddr = IDX_W'(req.rule_slot);
    assign mem_wdata = {req.rule_from, req.rule_event, req.rule_to, req.rule_notify};
    assign mem_raddr = (state_reg == S_IDLE) ? '0 : idx_plus1[IDX_W-1:0];

    always_comb
    begin
        mem_ctl.we = accept && (req.opcode == OP_WRITE) && slot_ok;
        mem_ctl.re = (accept && (req.opcode == OP_EVENT) && (lim != '0))
                  || ((state_reg == S_SCAN) && !match && !last);
    end

    always_comb
    begin
        res_load   = 1'b0;
        res_status = ST_NOMATCH;
        res_next   = cur_reg;
        res_notify = 1'b0;
        res_echo   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_EVENT:
                        begin
                            res_load = (lim == '0);
                            res_echo = req.event_req;
                        end
                        OP_WRITE:
                        begin
                            res_load   = 1'b1;
                            res_status = ST_STORED;
                        end
                        OP_RESTART:
                        begin
                            res_load   = 1'b1;
                            res_status = ST_RESTART;
                            res_next   = start_state;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                res_echo = ev_reg;
                if (match)
                begin
                    res_load   = 1'b1;
                    res_status = ST_TAKEN;
                    res_next   = rd_to;
                    res_notify = rd_notify;
                end
                else if (last)
                begin
                    res_load = 1'b1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
                cur_reg       <= res_next;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req.opcode == OP_EVENT))
                    begin
                        idx_reg <= '0;
                        if (lim != '0)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (last)
                    begin
                        idx_reg   <= lim_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_plus1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg  <= req.event_req;
            lim_reg <= lim;
        end
        if (res_load)
        begin
            status_reg <= res_status;
            prior_reg  <= cur_reg;
            next_reg   <= res_next;
            notify_reg <= res_notify;
            echo_reg   <= res_echo;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.prior_state = prior_reg;
    assign rsp.next_state  = next_reg;
    assign rsp.notify      = notify_reg;
    assign rsp.event_echo  = echo_reg;

    assign seq_state  = state_reg;
    assign scan_index = idx_reg;
    assign scan_limit = lim_reg;

endmodule

/* src/table_driven_state_machine_unit.sv */
// Top level of the table-driven state machine unit.
// Channels: req carries one request (event, rule write or restart); rsp returns
// one response per request; cfg writes rule_count (index 0) and start_state
// (index 1) and is always ready.
// Rule writes, restarts and events with a zero rule count answer on rsp in the
// cycle after acceptance. An event scans the rule store one slot per cycle
// through a single registered read port and one comparator, reading slots in order
// until one matches or min(rule_count, RULE_SLOTS) slots have been read; the
// response is then loaded. A new request is taken only when no scan runs and
// the previous response has been taken or is taken in the same cycle.
// req.ready is low during a scan and while a response waits on a stalled
// receiver; the response register holds its contents until rsp.ready.
// Reset clears the current state, the scan index and both registers; rule
// slots hold nothing defined until written.
module table_driven_state_machine_unit
    import tdsm_pkg::*;
#(
    parameter int RULE_SLOTS = 16,
    parameter int STATE_BITS = 8,
    parameter int EVENT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tdsm_req_if.sink   req,
    tdsm_rsp_if.source rsp,
    tdsm_cfg_if.sink   cfg
);

    localparam int IDX_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam int RULE_W = 2 * STATE_BITS + EVENT_BITS + 1;

    logic [RC_W-1:0]       rule_count_reg;
    logic [STATE_BITS-1:0] start_state_reg;

    mem_ctl_t              mem_ctl;
    logic [IDX_W-1:0]      mem_waddr;
    logic [RULE_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [RULE_W-1:0]     mem_rdata;
    seq_state_t            seq_state;
    logic [CNT_W-1:0]      scan_index;
    logic [CNT_W-1:0]      scan_limit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg  <= '0;
            start_state_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_RULE_COUNT:  rule_count_reg  <= cfg.data[RC_W-1:0];
                CFG_START_STATE: start_state_reg <= cfg.data[STATE_BITS-1:0];
                default:         rule_count_reg  <= rule_count_reg;
            endcase
        end
    end

    tdsm_seq #(
        .RULE_SLOTS (RULE_SLOTS),
        .STATE_BITS (STATE_BITS),
        .EVENT_BITS (EVENT_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .RULE_W     (RULE_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .rule_count  (rule_count_reg),
        .start_state (start_state_reg),
        .mem_ctl     (mem_ctl),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .seq_state   (seq_state),
        .scan_index  (scan_index),
        .scan_limit  (scan_limit)
    );

    tdsm_rule_mem #(
        .RULE_SLOTS (RULE_SLOTS),
        .IDX_W      (IDX_W),
        .RULE_W     (RULE_W)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // scan pointer stays inside the active range
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state == S_SCAN) |-> (scan_index < scan_limit))
        else $error("scan index beyond limit");

    // no new request while a response is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request taken over stalled response");

    // rule write answers next cycle with stored status
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == OP_WRITE))
        |=> (rsp.valid && (rsp.status == ST_STORED)))
        else $error("rule write response missing");

    // restart lands on the configured start state
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == OP_RESTART))
        |=> (rsp.next_state == $past(start_state_reg)))
        else $error("restart state mismatch");

endmodule

/* verif/tb_table_driven_state_machine_unit.sv */
`timescale 1ns / 100ps
// Testbench for table_driven_state_machine_unit, checked against an in-bench machine copy.
module tb_table_driven_state_machine_unit
    import tdsm_pkg::*;
();

    localparam int RULE_SLOTS = 16;
    localparam int STATE_BITS = 8;
    localparam int EVENT_BITS = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;
    localparam int MAX_REPORTS = 10;
    localparam int ITEMS_PER_SETTING = 100;
    localparam int SETTINGS_PER_PHASE = 5;
    localparam int TIMEOUT_NS = 4_000_000;

    typedef logic [STATE_BITS-1:0] fsm_state_t;
    typedef logic [EVENT_BITS-1:0] fsm_event_t;

    typedef struct {
        logic [1:0]        opcode;
        logic [SLOT_W-1:0] rule_slot;
        fsm_state_t        rule_from;
        fsm_event_t        rule_event;
        fsm_state_t        rule_to;
        logic              rule_notify;
        fsm_event_t        event_req;
    } request_t;

    typedef struct {
        status_t    status;
        fsm_state_t prior_state;
        fsm_state_t next_state;
        logic       notify;
        fsm_event_t event_echo;
    } response_t;

    logic clk;
    logic rst_n;

    tdsm_req_if #(.STATE_BITS(STATE_BITS), .EVENT_BITS(EVENT_BITS)) req_ch ();
    tdsm_rsp_if #(.STATE_BITS(STATE_BITS), .EVENT_BITS(EVENT_BITS)) rsp_ch ();
    tdsm_cfg_if cfg_ch ();

    table_driven_state_machine_unit #(
        .RULE_SLOTS(RULE_SLOTS),
        .STATE_BITS(STATE_BITS),
        .EVENT_BITS(EVENT_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg(cfg_ch)
    );

    // machine copy kept in step with accepted requests
    fsm_state_t       machine_state;
    fsm_state_t       tbl_from   [RULE_SLOTS];
    fsm_event_t       tbl_event  [RULE_SLOTS];
    fsm_state_t       tbl_to     [RULE_SLOTS];
    logic             tbl_notify [RULE_SLOTS];
    logic [RC_W-1:0]  rule_count_reg;
    fsm_state_t       start_state_reg;

    response_t due_responses[$];

    int errors;
    int requests_sent;
    int cfg_writes;
    int status_seen[4];
    int src_idle_pct;
    int sink_idle_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d responses outstanding", due_responses.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic request_t make_request(input logic [1:0] op,
                                              input logic [SLOT_W-1:0] slot,
                                              input fsm_state_t from_st, input fsm_event_t ev,
                                              input fsm_state_t to_st, input logic ntf,
                                              input fsm_event_t ev_req);
        request_t it;
        it.opcode      = op;
        it.rule_slot   = slot;
        it.rule_from   = from_st;
        it.rule_event  = ev;
        it.rule_to     = to_st;
        it.rule_notify = ntf;
        it.event_req   = ev_req;
        return it;
    endfunction

    function automatic response_t advance_machine(input request_t it);
        response_t r;
        int limit;
        bit hit;
        logic [SLOT_W-1:0] slot;
        r.status      = ST_NOMATCH;
        r.prior_state = machine_state;
        r.next_state  = machine_state;
        r.notify      = 1'b0;
        r.event_echo  = '0;
        case (it.opcode)
            OP_EVENT:
            begin
                limit = (rule_count_reg > RULE_SLOTS) ? RULE_SLOTS : int'(rule_count_reg);
                hit = 1'b0;
                r.event_echo = it.event_req;
                for (int i = 0; i < limit && !hit; i++)
                begin
                    slot = SLOT_W'(i);
                    if (tbl_from[slot] == machine_state && tbl_event[slot] == it.event_req)
                    begin
                        hit = 1'b1;
                        machine_state = tbl_to[slot];
                        r.status = ST_TAKEN;
                        r.notify = tbl_notify[slot];
                    end
                end
            end
            OP_WRITE:
            begin
                tbl_from[it.rule_slot]   = it.rule_from;
                tbl_event[it.rule_slot]  = it.rule_event;
                tbl_to[it.rule_slot]     = it.rule_to;
                tbl_notify[it.rule_slot] = it.rule_notify;
                r.status = ST_STORED;
            end
            OP_RESTART:
            begin
                machine_state = start_state_reg;
                r.status = ST_RESTART;
            end
            default: ;
        endcase
        r.next_state = machine_state;
        return r;
    endfunction

    function automatic fsm_state_t pick_state();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h10;
            3: return 8'h5A;
            4: return 8'hA5;
            5: return 8'h33;
            6: return 8'hC3;
            7: return 8'h81;
            default: return fsm_state_t'($urandom);
        endcase
    endfunction

    function automatic fsm_event_t pick_event();
        case ($urandom_range(6))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'h7E;
            4: return 8'h80;
            default: return fsm_event_t'($urandom);
        endcase
    endfunction

    // events, many of which follow a stored rule, with rule updates, restarts and unused opcodes mixed in
    function automatic request_t random_request();
        request_t it;
        int pick;
        int limit;
        logic [SLOT_W-1:0] cand[$];
        it = make_request(OP_EVENT, SLOT_W'($urandom), fsm_state_t'($urandom),
                          fsm_event_t'($urandom), fsm_state_t'($urandom), 1'($urandom),
                          fsm_event_t'($urandom));
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            limit = (rule_count_reg > RULE_SLOTS) ? RULE_SLOTS : int'(rule_count_reg);
            for (int i = 0; i < limit; i++)
                if (tbl_from[SLOT_W'(i)] == machine_state)
                    cand.push_back(SLOT_W'(i));
            if (cand.size() > 0 && $urandom_range(99) < 75)
                it.event_req = tbl_event[cand[$urandom_range(cand.size() - 1)]];
            else if ($urandom_range(1) == 1)
                it.event_req = pick_event();
        end
        else if (pick < 80)
        begin
            it.opcode = OP_WRITE;
            it.rule_from = ($urandom_range(3) == 0) ? machine_state : pick_state();
            if ($urandom_range(9) < 7)
                it.rule_event = pick_event();
            if ($urandom_range(9) < 8)
                it.rule_to = pick_state();
        end
        else if (pick < 95)
            it.opcode = OP_RESTART;
        else
            it.opcode = OP_UNUSED;
        return it;
    endfunction

    task automatic send_request(input request_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 200)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= it.opcode;
        req_ch.rule_slot   <= it.rule_slot;
        req_ch.rule_from   <= it.rule_from;
        req_ch.rule_event  <= it.rule_event;
        req_ch.rule_to     <= it.rule_to;
        req_ch.rule_notify <= it.rule_notify;
        req_ch.event_req   <= it.event_req;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        due_responses.push_back(advance_machine(it));
        requests_sent++;
    endtask

    task automatic wait_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_responses.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data,
                                  input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_RULE_COUNT:  rule_count_reg  = data[RC_W-1:0];
            CFG_START_STATE: start_state_reg = data[STATE_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input int rc, input fsm_state_t ss);
        wait_responses();
        write_register(CFG_RULE_COUNT, rc, 1'b0);
        write_register(CFG_START_STATE, ss, 1'b1);
    endtask

    // reset values: empty scan, start state zero
    task automatic test_empty_table();
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_request(make_request(OP_EVENT, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
        send_request(make_request(OP_UNUSED, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
        send_request(make_request(OP_RESTART, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
    endtask

    task automatic test_rule_table();
        send_request(make_request(OP_WRITE, 4'd0, 8'h00, 8'h01, 8'h10, 1'b1, 8'h00));
        send_request(make_request(OP_WRITE, 4'd1, 8'h10, 8'hFF, 8'hFF, 1'b0, 8'h00));
        send_request(make_request(OP_WRITE, 4'd2, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00));
        // same match as slot 1, never reached
        send_request(make_request(OP_WRITE, 4'd3, 8'h10, 8'hFF, 8'h33, 1'b1, 8'h00));
        for (int i = 4; i < RULE_SLOTS - 1; i++)
            send_request(make_request(OP_WRITE, SLOT_W'(i), fsm_state_t'(8'h40 + i),
                                      fsm_event_t'(8'h80 + i), fsm_state_t'($urandom),
                                      i[0], 8'h00));
        send_request(make_request(OP_WRITE, 4'd15, 8'hAA, 8'h55, 8'h5A, 1'b1, 8'h00));
        configure(RULE_SLOTS, 8'hAA);
    endtask

    task automatic test_transitions();
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h01));
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF));
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h77));
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_request(make_request(OP_RESTART, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h55));
        send_request(make_request(OP_UNUSED, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        // oversized rule count, upper data bits set, write to an unmapped index
        wait_responses();
        write_register(CFG_RULE_COUNT, 32'hFFFF_FFFF, 1'b0);
        write_register(CFG_SPARE_IDX, 32'h0000_0005, 1'b0);
        write_register(CFG_START_STATE, 32'h1234_56FF, 1'b1);
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h99));
        send_request(make_request(OP_RESTART, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        send_request(make_request(OP_EVENT, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
    endtask

    task automatic test_random_traffic(input int phase);
        int rc;
        fsm_state_t ss;
        case (phase)
            0:
            begin
                src_idle_pct  = 8;
                sink_idle_pct = 86;
            end
            1:
            begin
                src_idle_pct  = 86;
                sink_idle_pct = 8;
            end
            default:
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
        for (int s = 0; s < SETTINGS_PER_PHASE; s++)
        begin
            case (s)
                0: rc = RULE_SLOTS;
                1: rc = $urandom_range(RULE_SLOTS - 1, 2);
                2: rc = (phase == 0) ? 0 : 1;
                3: rc = $urandom_range(31, RULE_SLOTS + 1);
                default: rc = $urandom_range(RULE_SLOTS, 0);
            endcase
            case (s)
                2: ss = 8'hFF;
                4: ss = 8'h00;
                default: ss = pick_state();
            endcase
            configure(rc, ss);
            repeat (ITEMS_PER_SETTING)
                send_request(random_request());
        end
    endtask

    // receiver stops long enough for the unit to back up into the request side
    task automatic test_receiver_stall();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        configure(RULE_SLOTS, pick_state());
        hold_left = 300;
        repeat (24)
            send_request(random_request());
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        response_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (due_responses.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"unexpected response: status %0d prior %02h next %02h",
                                  " notify %0b echo %02h"},
                                 rsp_ch.status, rsp_ch.prior_state, rsp_ch.next_state,
                                 rsp_ch.notify, rsp_ch.event_echo);
                end
                else
                begin
                    want = due_responses.pop_front();
                    status_seen[want.status]++;
                    if (rsp_ch.status !== want.status ||
                        rsp_ch.prior_state !== want.prior_state ||
                        rsp_ch.next_state !== want.next_state || rsp_ch.notify !== want.notify ||
                        rsp_ch.event_echo !== want.event_echo)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display({"mismatch at %0t: expected status %0d prior %02h",
                                      " next %02h notify %0b echo %02h"},
                                     $realtime, want.status, want.prior_state, want.next_state,
                                     want.notify, want.event_echo);
                            $display({"                 got status %0d prior %02h",
                                      " next %02h notify %0b echo %02h"},
                                     rsp_ch.status, rsp_ch.prior_state, rsp_ch.next_state,
                                     rsp_ch.notify, rsp_ch.event_echo);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int spins;
        errors          = 0;
        requests_sent   = 0;
        cfg_writes      = 0;
        status_seen     = '{0, 0, 0, 0};
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        hold_left       = 0;
        machine_state   = '0;
        rule_count_reg  = '0;
        start_state_reg = '0;
        for (int i = 0; i < RULE_SLOTS; i++)
        begin
            tbl_from[SLOT_W'(i)]   = '0;
            tbl_event[SLOT_W'(i)]  = '0;
            tbl_to[SLOT_W'(i)]     = '0;
            tbl_notify[SLOT_W'(i)] = 1'b0;
        end
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_EVENT;
        req_ch.rule_slot   = '0;
        req_ch.rule_from   = '0;
        req_ch.rule_event  = '0;
        req_ch.rule_to     = '0;
        req_ch.rule_notify = 1'b0;
        req_ch.event_req   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_RULE_COUNT;
        cfg_ch.data        = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_rule_table();
        test_transitions();
        for (int p = 0; p < 3; p++)
            test_random_traffic(p);
        test_receiver_stall();

        req_ch.valid <= 1'b0;
        spins = 0;
        while (due_responses.size() != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (2 * RULE_SLOTS + 4) @(posedge clk);
        if (due_responses.size() != 0)
        begin
            errors++;
            $display("%0d responses never arrived", due_responses.size());
        end

        $display("%0d requests and %0d register writes over rule counts 0..31 and three idle mixes",
                 requests_sent, cfg_writes);
        $display("responses: %0d taken, %0d no match, %0d stored, %0d restarted; %0d errors",
                 status_seen[ST_TAKEN], status_seen[ST_NOMATCH], status_seen[ST_STORED],
                 status_seen[ST_RESTART], errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
